### rtl/mtep_pkg.sv
// mtep_pkg: parse phases, event kinds and byte codes of the track event parser
// depends on nothing
package mtep_pkg;

	typedef enum logic [3:0] {
		PH_DELTA0      = 4'd0,
		PH_DELTA1      = 4'd1,
		PH_DELTA2      = 4'd2,
		PH_DELTA3      = 4'd3,
		PH_EVENT       = 4'd4,
		PH_DATA1       = 4'd5,
		PH_DATA2       = 4'd6,
		PH_SKIP        = 4'd7,
		PH_META_TYPE   = 4'd8,
		PH_META_LEN    = 4'd9,
		PH_META_DATA   = 4'd10,
		PH_SYSEX_FIRST = 4'd11,
		PH_SYSEX_DATA  = 4'd12
	} phase_t;

	typedef logic [2:0] kind_t;

	localparam kind_t EV_TEMPO = 3'd7;

	localparam logic [7:0] B_META      = 8'hFF;
	localparam logic [7:0] B_SYSEX     = 8'hF0;
	localparam logic [7:0] B_SYSEX_END = 8'hF7;
	localparam logic [7:0] B_MTC       = 8'hF1;
	localparam logic [7:0] B_SONG_POS  = 8'hF2;
	localparam logic [7:0] B_SONG_SEL  = 8'hF3;
	localparam logic [7:0] B_TEMPO     = 8'h51;
	localparam logic [3:0] HI_SYSTEM   = 4'hF;
	localparam logic [3:0] HI_PROGRAM  = 4'hC;
	localparam logic [3:0] HI_CHAN_PRS = 4'hD;
	localparam logic [3:0] HI_BEND     = 4'hE;

endpackage

### rtl/mtep_if.sv
// mtep_byte_if, mtep_event_if: valid/ready channels of the track event parser
// depends on nothing

interface mtep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       track_end;

	modport source (output valid, output data_byte, output track_end, input ready);
	modport sink (input valid, input data_byte, input track_end, output ready);
endinterface

interface mtep_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [3:0]  channel;
	logic [7:0]  first_data;
	logic [7:0]  second_data;
	logic [23:0] wide_value;
	logic [31:0] event_time;

	modport source (output valid, output event_kind, output channel, output first_data,
		output second_data, output wide_value, output event_time, input ready);
	modport sink (input valid, input event_kind, input channel, input first_data,
		input second_data, input wide_value, input event_time, output ready);
endinterface

### rtl/midi_track_event_parser.sv
// midi_track_event_parser: standard midi file track parser, one byte per item
// depends on mtep_pkg and the channel interfaces in mtep_if.sv
//
// usage:
//   bytes  carries the track chunk, one byte per item, with track_end set on
//          the last byte of the track
//   events carries decoded channel messages and tempo changes, each stamped
//          with the accumulated tick time
//   a byte is registered in the input register at acceptance and parsed from
//   there, where the state machine and the result register are updated; a
//   result is offered from the result register once its last byte has passed
//   through the input register and been parsed
//   one byte per cycle is sustained while events does not stall; the only
//   loop is the parse state
//   while events is stalled with a result waiting, the byte in the input
//   register holds and bytes stays low once that register is full
//   reset (arst_n low) clears all parse state, the tick count and both
//   registers; the byte marked track_end is parsed normally and then
//   returns all parse state and the tick count to their reset values
module midi_track_event_parser (
	input  logic                clk,
	input  logic                arst_n,
	mtep_byte_if.sink           bytes,
	mtep_event_if.source        events
);
	import mtep_pkg::*;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        advance;

	phase_t      phase_q, phase_d;
	logic [27:0] delta_q, delta_d;
	logic [31:0] tick_q, tick_d;
	logic [7:0]  run_status_q, run_status_d;
	logic        run_valid_q, run_valid_d;
	logic [7:0]  cur_status_q, cur_status_d;
	logic [7:0]  held_q, held_d;
	logic [7:0]  meta_type_q, meta_type_d;
	logic [27:0] meta_rem_q, meta_rem_d;
	logic [1:0]  meta_idx_q, meta_idx_d;
	logic [23:0] tempo_q, tempo_d;
	logic [1:0]  skip_q, skip_d;

	logic        delta_en;
	logic [1:0]  delta_pos;
	logic [27:0] delta_new;
	logic        delta_more;
	phase_t      delta_phase;
	logic [7:0]  eff_status;
	logic        short_msg;
	logic [27:0] meta_len_new;
	logic [23:0] tempo_new;

	logic        emit;
	kind_t       kind_d;
	logic [3:0]  chan_d;
	logic [7:0]  first_d, second_d;
	logic [23:0] wide_d;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [3:0]  chan_q;
	logic [7:0]  first_q, second_q;
	logic [23:0] wide_q;
	logic [31:0] time_q;

	assign advance = v_s1 && (!out_valid_q || events.ready);
	assign bytes.ready = !v_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (bytes.ready) begin
			v_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
			end_s1  <= bytes.track_end;
		end
	end

	// shared decode
	always_comb begin
		delta_en  = 1'b0;
		delta_pos = 2'd0;
		unique case (phase_q)
			PH_DELTA0, PH_DELTA1, PH_DELTA2, PH_DELTA3: begin
				delta_en  = 1'b1;
				delta_pos = phase_q[1:0];
			end
			PH_SYSEX_DATA: begin
				delta_en = byte_s1[7] && (byte_s1 != B_SYSEX_END);
			end
			PH_EVENT, PH_DATA1, PH_DATA2, PH_SKIP, PH_META_TYPE, PH_META_LEN,
			PH_META_DATA, PH_SYSEX_FIRST: begin
				delta_en = 1'b0;
			end
			default: begin
				delta_en = 1'b1;
			end
		endcase
		delta_new    = (delta_pos == 2'd0) ? {21'd0, byte_s1[6:0]}
		                                   : {delta_q[20:0], byte_s1[6:0]};
		delta_more   = byte_s1[7] && (delta_pos != 2'd3);
		delta_phase  = delta_more ? phase_t'({2'b00, delta_pos + 2'd1}) : PH_EVENT;
		eff_status   = (phase_q == PH_EVENT) ? run_status_q : cur_status_q;
		short_msg    = (eff_status[7:4] == HI_PROGRAM) || (eff_status[7:4] == HI_CHAN_PRS);
		meta_len_new = {meta_rem_q[20:0], byte_s1[6:0]};
		tempo_new    = {tempo_q[15:0], byte_s1};
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_EVENT: begin
				if (byte_s1 == B_META) begin
					phase_d = PH_META_TYPE;
				end else if (byte_s1[7:4] == HI_SYSTEM) begin
					case (byte_s1) inside
						B_SYSEX: phase_d = PH_SYSEX_FIRST;
						B_MTC, B_SONG_SEL, B_SONG_POS: phase_d = PH_SKIP;
						default: phase_d = PH_DELTA0;
					endcase
				end else if (byte_s1[7]) begin
					phase_d = PH_DATA1;
				end else if (run_valid_q) begin
					phase_d = short_msg ? PH_DELTA0 : PH_DATA2;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_DATA1: phase_d = short_msg ? PH_DELTA0 : PH_DATA2;
			PH_DATA2: phase_d = PH_DELTA0;
			PH_SKIP: phase_d = (skip_q == 2'd1) ? PH_DELTA0 : PH_SKIP;
			PH_META_TYPE: phase_d = PH_META_LEN;
			PH_META_LEN: begin
				if (byte_s1[7] && meta_idx_q != 2'd3) begin
					phase_d = PH_META_LEN;
				end else begin
					phase_d = (meta_len_new == 28'd0) ? PH_DELTA0 : PH_META_DATA;
				end
			end
			PH_META_DATA: phase_d = (meta_rem_q == 28'd1) ? PH_DELTA0 : PH_META_DATA;
			PH_SYSEX_FIRST: phase_d = PH_SYSEX_DATA;
			PH_SYSEX_DATA: begin
				if (!byte_s1[7]) begin
					phase_d = PH_SYSEX_DATA;
				end else if (byte_s1 == B_SYSEX_END) begin
					phase_d = PH_DELTA0;
				end else begin
					phase_d = delta_phase;
				end
			end
			default: phase_d = delta_phase;
		endcase
		if (end_s1) begin
			phase_d = PH_DELTA0;
		end
	end

	// datapath and result
	always_comb begin
		delta_d      = delta_q;
		tick_d       = tick_q;
		run_status_d = run_status_q;
		run_valid_d  = run_valid_q;
		cur_status_d = cur_status_q;
		held_d       = held_q;
		meta_type_d  = meta_type_q;
		meta_rem_d   = meta_rem_q;
		meta_idx_d   = meta_idx_q;
		tempo_d      = tempo_q;
		skip_d       = skip_q;
		emit         = 1'b0;
		kind_d       = eff_status[6:4];
		chan_d       = eff_status[3:0];
		first_d      = 8'd0;
		second_d     = 8'd0;
		wide_d       = 24'd0;

		if (delta_en) begin
			delta_d = delta_new;
			if (!delta_more) begin
				tick_d = tick_q + {4'd0, delta_new};
			end
		end

		unique case (phase_q)
			PH_EVENT: begin
				if (byte_s1[7:4] == HI_SYSTEM) begin
					run_valid_d  = 1'b0;
					run_status_d = 8'd0;
					case (byte_s1) inside
						B_MTC, B_SONG_SEL: skip_d = 2'd1;
						B_SONG_POS: skip_d = 2'd2;
						default: skip_d = skip_q;
					endcase
				end else if (byte_s1[7]) begin
					run_status_d = byte_s1;
					run_valid_d  = 1'b1;
					cur_status_d = byte_s1;
				end else if (run_valid_q) begin
					cur_status_d = run_status_q;
					if (short_msg) begin
						emit    = 1'b1;
						first_d = byte_s1;
					end else begin
						held_d = byte_s1;
					end
				end else begin
					skip_d = 2'd1;
				end
			end
			PH_DATA1: begin
				if (short_msg) begin
					emit    = 1'b1;
					first_d = byte_s1;
				end else begin
					held_d = byte_s1;
				end
			end
			PH_DATA2: begin
				emit     = 1'b1;
				first_d  = held_q;
				second_d = byte_s1;
				if (cur_status_q[7:4] == HI_BEND) begin
					wide_d = {9'd0, byte_s1, 7'd0} + {16'd0, held_q};
				end
			end
			PH_SKIP: skip_d = skip_q - 2'd1;
			PH_META_TYPE: begin
				meta_type_d = byte_s1;
				meta_rem_d  = 28'd0;
				meta_idx_d  = 2'd0;
			end
			PH_META_LEN: begin
				meta_rem_d = meta_len_new;
				if (byte_s1[7] && meta_idx_q != 2'd3) begin
					meta_idx_d = meta_idx_q + 2'd1;
				end else begin
					meta_idx_d = 2'd0;
					tempo_d    = 24'd0;
				end
			end
			PH_META_DATA: begin
				meta_rem_d = meta_rem_q - 28'd1;
				if (meta_type_q == B_TEMPO && meta_idx_q != 2'd3) begin
					tempo_d    = tempo_new;
					meta_idx_d = meta_idx_q + 2'd1;
					if (meta_idx_q == 2'd2) begin
						emit   = 1'b1;
						kind_d = EV_TEMPO;
						chan_d = 4'd0;
						wide_d = tempo_new;
					end
				end
			end
			default: begin
				skip_d = skip_q;
			end
		endcase

		if (end_s1) begin
			delta_d      = 28'd0;
			tick_d       = 32'd0;
			run_status_d = 8'd0;
			run_valid_d  = 1'b0;
			cur_status_d = 8'd0;
			held_d       = 8'd0;
			meta_type_d  = 8'd0;
			meta_rem_d   = 28'd0;
			meta_idx_d   = 2'd0;
			tempo_d      = 24'd0;
			skip_d       = 2'd0;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DELTA0;
			delta_q      <= '0;
			tick_q       <= '0;
			run_status_q <= '0;
			run_valid_q  <= 1'b0;
			cur_status_q <= '0;
			held_q       <= '0;
			meta_type_q  <= '0;
			meta_rem_q   <= '0;
			meta_idx_q   <= '0;
			tempo_q      <= '0;
			skip_q       <= '0;
		end else if (advance) begin
			phase_q      <= phase_d;
			delta_q      <= delta_d;
			tick_q       <= tick_d;
			run_status_q <= run_status_d;
			run_valid_q  <= run_valid_d;
			cur_status_q <= cur_status_d;
			held_q       <= held_d;
			meta_type_q  <= meta_type_d;
			meta_rem_q   <= meta_rem_d;
			meta_idx_q   <= meta_idx_d;
			tempo_q      <= tempo_d;
			skip_q       <= skip_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q   <= kind_d;
			chan_q   <= chan_d;
			first_q  <= first_d;
			second_q <= second_d;
			wide_q   <= wide_d;
			time_q   <= tick_q;
		end
	end

	assign events.valid       = out_valid_q;
	assign events.event_kind  = kind_q;
	assign events.channel     = chan_q;
	assign events.first_data  = first_q;
	assign events.second_data = second_q;
	assign events.wide_value  = wide_q;
	assign events.event_time  = time_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> bytes.ready)
		else $error("input register empty but bytes not ready");

	a_track_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && end_s1) |=> (phase_q == PH_DELTA0 && tick_q == 32'd0 && !run_valid_q))
		else $error("state not cleared after track end");

	a_tempo_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == EV_TEMPO) |-> (chan_q == 4'd0 && first_q == 8'd0
		&& second_q == 8'd0))
		else $error("tempo item carries channel data");

	a_result_from_parse: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result appeared without a parsed byte");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_q != 2'd0))
		else $error("skip phase with zero count");

endmodule
